// ===== design/rxrb_pkg.sv =====
// ----------------------------------------------------------------------------
// rxrb_pkg
// Types and constants shared by the receive ring buffer modules.
// ----------------------------------------------------------------------------
package rxrb_pkg;

	localparam int unsigned MAX_DEPTH_DEF = 64;
	localparam int unsigned LEN_W         = 7;
	localparam int unsigned BYTE_W        = 8;
	localparam int unsigned CFG_IDX_W     = 2;

	localparam logic [LEN_W-1:0] LEN_RESET    = 7'd64;
	localparam logic [LEN_W-1:0] THR_RESET    = 7'd32;
	localparam logic [LEN_W-1:0] LEN_MIN      = 7'd2;
	localparam logic [LEN_W-1:0] RESULT_LIMIT = 7'd64;

	typedef enum logic [1:0] {
		EV_NONE      = 2'd0,
		EV_THRESHOLD = 2'd1,
		EV_OVERFLOW  = 2'd2
	} event_t;

	typedef enum logic {
		OP_PUSH = 1'b0,
		OP_READ = 1'b1
	} opcode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LENGTH    = 2'd0,
		CFG_THRESHOLD = 2'd1,
		CFG_RX_EN     = 2'd2,
		CFG_EV_EN     = 2'd3
	} cfg_idx_t;

	typedef enum logic {
		ST_IDLE,
		ST_READ
	} state_t;

	typedef struct packed {
		opcode_t             opcode;
		logic [BYTE_W-1:0]   rx_byte;
		logic [LEN_W-1:0]    read_count;
	} in_t;

	typedef struct packed {
		event_t              event_code;
		logic [BYTE_W-1:0]   data_byte;
		logic                last_of_read;
		logic                underflow;
		logic [LEN_W-1:0]    fill_level;
	} out_t;

	// controller to datapath
	typedef struct packed {
		logic push;
		logic pop;
		logic last;
	} cmd_t;

endpackage

// ===== design/rx_ring_buffer_with_threshold_unit.sv =====
// ----------------------------------------------------------------------------
// rx_ring_buffer_with_threshold_unit
// Receive byte ring buffer with fill threshold and overflow events.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_ready/in_data) carries push and read items.
//    A push stores one byte and, when reception is enabled, gives one result
//    item carrying the event code and the fill level; a disabled push is
//    taken and dropped. A read item gives read_count results (capped at 64),
//    one popped byte each, the final one marked; a count of zero gives none.
//  - Output channel (out_valid/out_ready/out_data) is fed from a single
//    result register; a result appears in the cycle after its item or pop.
//  - A read run takes the item, then makes one pop per cycle while the
//    receiver does not stall; the byte store has a single read port,
//    which prefetches the entry at the next read pointer.
//  - While the receiver stalls, the result register holds and no further
//    item or pop is taken until it drains.
//  - Settings are written through cfg_wr_en/cfg_index/cfg_data while idle;
//    writing the length empties the ring but keeps the stored bytes.
//  - Reset empties the ring, loads length 64 / threshold 32, disables
//    reception and events, and clears the per-entry valid bits so the whole
//    store reads as zero at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module rx_ring_buffer_with_threshold_unit #(
	parameter int unsigned MAX_DEPTH = rxrb_pkg::MAX_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  rxrb_pkg::in_t                   in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output rxrb_pkg::out_t                  out_data,
	input  logic                            cfg_wr_en,
	input  logic [rxrb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rxrb_pkg::LEN_W-1:0]      cfg_data
);
	import rxrb_pkg::*;

	cmd_t cmd;     // push / pop strobes from the controller
	logic rx_en;   // reception enable, held in the datapath settings

	rxrb_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.opcode     (in_data.opcode),
		.read_count (in_data.read_count),
		.rx_en      (rx_en),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.cmd        (cmd)
	);

	rxrb_dpath #(
		.MAX_DEPTH (MAX_DEPTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.rx_byte   (in_data.rx_byte),
		.rx_en     (rx_en),
		.out_data  (out_data)
	);

	// the final result of a read never carries an event
	a_read_no_event : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.last_of_read |-> out_data.event_code == EV_NONE)
		else $error("read result carries an event");

	// an underflowing pop leaves the ring empty
	a_under_empty : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.underflow |-> out_data.fill_level == '0)
		else $error("underflow with non-zero fill");

	// overflow empties the ring
	a_ovf_empty : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.event_code == EV_OVERFLOW |-> out_data.fill_level == '0)
		else $error("overflow did not empty the ring");

	// no item is taken while a pop run is in progress
	a_no_take_in_run : assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop && !cmd.last |=> !in_ready)
		else $error("item taken during a read run");

endmodule

// ===== design/rxrb_ctrl.sv =====
// ----------------------------------------------------------------------------
// rxrb_ctrl
// Handshake control: takes items, sequences read runs, owns output valid.
// ----------------------------------------------------------------------------
module rxrb_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  rxrb_pkg::opcode_t            opcode,
	input  logic [rxrb_pkg::LEN_W-1:0]   read_count,
	input  logic                         rx_en,
	output logic                         out_valid,
	input  logic                         out_ready,
	output rxrb_pkg::cmd_t               cmd
);
	import rxrb_pkg::*;

	state_t           state_q, state_d;
	logic [LEN_W-1:0] cnt_q, cnt_d;
	logic             out_valid_q, out_valid_d;
	logic             slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		slot_free = !out_valid_q || out_ready;
		state_d   = state_q;
		cnt_d     = cnt_q;
		in_ready  = 1'b0;
		cmd       = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = slot_free;
				if (in_valid && slot_free) begin
					if (opcode == OP_PUSH) begin
						cmd.push = rx_en;
					end else if (read_count != '0) begin
						state_d = ST_READ;
						cnt_d   = (read_count > RESULT_LIMIT) ? RESULT_LIMIT : read_count;
					end
				end
			end
			ST_READ: begin
				if (slot_free) begin
					cmd.pop  = 1'b1;
					cmd.last = (cnt_q == LEN_W'(1));
					cnt_d    = cnt_q - LEN_W'(1);
					if (cmd.last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (cmd.push || cmd.pop) begin
			out_valid_d = 1'b1;
		end else if (out_ready) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== design/rxrb_dpath.sv =====
// ----------------------------------------------------------------------------
// rxrb_dpath
// Byte store, pointers, fill count, settings and the result register.
// ----------------------------------------------------------------------------
module rxrb_dpath #(
	parameter int unsigned MAX_DEPTH = rxrb_pkg::MAX_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [rxrb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rxrb_pkg::LEN_W-1:0]      cfg_data,
	input  rxrb_pkg::cmd_t                  cmd,
	input  logic [rxrb_pkg::BYTE_W-1:0]     rx_byte,
	output logic                            rx_en,
	output rxrb_pkg::out_t                  out_data
);
	import rxrb_pkg::*;

	localparam int unsigned IW  = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
	localparam int unsigned CW  = ((IW > LEN_W) ? IW : LEN_W) + 1;
	localparam int unsigned CAP = (MAX_DEPTH < 127) ? MAX_DEPTH : 127;
	localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(CAP);

	function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] n);
		logic [LEN_W-1:0] r;
		r = n;
		if (n < LEN_MIN) r = LEN_MIN;
		if (n > LEN_CAP) r = LEN_CAP;
		return r;
	endfunction

	function automatic logic [IW-1:0] advance(input logic [IW-1:0] idx,
			input logic [LEN_W-1:0] len);
		logic [CW-1:0] nx;
		nx = CW'(idx) + CW'(1);
		if (nx >= CW'(len)) return '0;
		return nx[IW-1:0];
	endfunction

	logic [LEN_W-1:0]  len_q, thr_q;
	logic              rx_en_q, ev_en_q;
	logic [IW-1:0]     wr_idx_q, wr_idx_d, rd_idx_q, rd_idx_d;
	logic [LEN_W-1:0]  fill_q, fill_d, fill_inc;
	logic              ovf, thr_hit, under, len_wr;

	logic [BYTE_W-1:0] mem [MAX_DEPTH];
	logic [MAX_DEPTH-1:0] vld_q;
	logic [BYTE_W-1:0] rd_data_q, byp_data_q, pop_data;
	logic              rd_vld_q, byp_q;

	out_t              out_q, out_d;
	event_t            ev;

	// settings
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= clamp_len(LEN_RESET);
			thr_q   <= THR_RESET;
			rx_en_q <= 1'b0;
			ev_en_q <= 1'b0;
		end else if (cfg_wr_en) begin
			case (cfg_idx_t'(cfg_index))
				CFG_LENGTH:    len_q   <= clamp_len(cfg_data);
				CFG_THRESHOLD: thr_q   <= cfg_data;
				CFG_RX_EN:     rx_en_q <= cfg_data[0];
				CFG_EV_EN:     ev_en_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	assign len_wr = cfg_wr_en && (cfg_idx_t'(cfg_index) == CFG_LENGTH);

	always_comb begin
		fill_inc = fill_q + LEN_W'(1);
		ovf      = (fill_inc >= len_q);
		thr_hit  = (fill_inc >= thr_q);
		under    = (fill_q == '0);
		wr_idx_d = wr_idx_q;
		rd_idx_d = rd_idx_q;
		fill_d   = fill_q;
		if (len_wr) begin
			wr_idx_d = '0;
			rd_idx_d = '0;
			fill_d   = '0;
		end else if (cmd.push) begin
			if (ovf) begin
				wr_idx_d = '0;
				rd_idx_d = '0;
				fill_d   = '0;
			end else begin
				wr_idx_d = advance(wr_idx_q, len_q);
				fill_d   = fill_inc;
			end
		end else if (cmd.pop) begin
			rd_idx_d = advance(rd_idx_q, len_q);
			fill_d   = under ? '0 : (fill_q - LEN_W'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q <= '0;
			rd_idx_q <= '0;
			fill_q   <= '0;
		end else begin
			wr_idx_q <= wr_idx_d;
			rd_idx_q <= rd_idx_d;
			fill_q   <= fill_d;
		end
	end

	// store; read port prefetches the entry at the next read pointer
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem[wr_idx_q] <= rx_byte;
		end
		rd_data_q  <= mem[rd_idx_d];
		byp_data_q <= rx_byte;
	end

	// never-written entries read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
			byp_q    <= 1'b0;
		end else begin
			if (cmd.push) begin
				vld_q[wr_idx_q] <= 1'b1;
			end
			rd_vld_q <= vld_q[rd_idx_d];
			byp_q    <= cmd.push && (wr_idx_q == rd_idx_d);
		end
	end

	assign pop_data = byp_q ? byp_data_q : (rd_vld_q ? rd_data_q : '0);

	always_comb begin
		if (!ev_en_q) begin
			ev = EV_NONE;
		end else if (ovf) begin
			ev = EV_OVERFLOW;
		end else if (thr_hit) begin
			ev = EV_THRESHOLD;
		end else begin
			ev = EV_NONE;
		end
		out_d = '0;
		out_d.fill_level = fill_d;
		if (cmd.push) begin
			out_d.event_code = ev;
		end else begin
			out_d.event_code   = EV_NONE;
			out_d.data_byte    = pop_data;
			out_d.last_of_read = cmd.last;
			out_d.underflow    = under;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push || cmd.pop) begin
			out_q <= out_d;
		end
	end

	assign rx_en    = rx_en_q;
	assign out_data = out_q;

endmodule

// ===== verif/rx_ring_buffer_with_threshold_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rx_ring_buffer_with_threshold_unit_test
// Self-checking bench for the receive ring buffer. A scoreboard object keeps
// its own copy of the ring, pointers, fill count and settings, turns every
// accepted push or read item into the result items it should cause, and
// checks each delivered result against the oldest one outstanding. Directed
// corner cases run first, then randomised phases under several settings,
// with bursty input traffic and a stalling receiver.
// ----------------------------------------------------------------------------
module rx_ring_buffer_with_threshold_unit_test;

	import rxrb_pkg::*;

	localparam int unsigned SETTLE_CYCLES = 8;    // covers pushes/reads that give no result
	localparam int unsigned HOLD_CYCLES   = 120;  // long receiver hold-off
	localparam int unsigned REPORT_LIMIT  = 10;

	// ------------------------------------------------------------------------
	// Scoreboard: ring predictor plus queue of outstanding result items
	// ------------------------------------------------------------------------
	class ring_scoreboard;
		logic [BYTE_W-1:0] ring [MAX_DEPTH_DEF];
		logic [5:0]        wr_ptr;
		logic [5:0]        rd_ptr;
		logic [LEN_W-1:0]  fill;
		logic [LEN_W-1:0]  len_reg;
		logic [LEN_W-1:0]  thr_reg;
		bit                rx_on;
		bit                ev_on;
		out_t              expected_q [$];
		int unsigned       faults;

		function new();
			foreach (ring[i])
				ring[i] = '0;
			wr_ptr  = '0;
			rd_ptr  = '0;
			fill    = '0;
			len_reg = LEN_RESET;
			thr_reg = THR_RESET;
			rx_on   = 1'b0;
			ev_on   = 1'b0;
			faults  = 0;
		endfunction

		// length in use, clamped to the legal ring sizes
		function logic [LEN_W-1:0] span();
			logic [LEN_W-1:0] n;
			n = len_reg;
			if (n < LEN_MIN)
				n = LEN_MIN;
			if (n > LEN_W'(MAX_DEPTH_DEF))
				n = LEN_W'(MAX_DEPTH_DEF);
			return n;
		endfunction

		function logic [5:0] step_ptr(logic [5:0] p);
			logic [LEN_W-1:0] nx;
			nx = {1'b0, p} + 7'd1;
			if (nx >= span())
				nx = '0;
			return nx[5:0];
		endfunction

		function void write_reg(cfg_idx_t idx, logic [LEN_W-1:0] val);
			case (idx)
				CFG_LENGTH: begin
					len_reg = val;
					wr_ptr  = '0;
					rd_ptr  = '0;
					fill    = '0;
				end
				CFG_THRESHOLD: thr_reg = val;
				CFG_RX_EN:     rx_on   = val[0];
				CFG_EV_EN:     ev_on   = val[0];
				default: ;
			endcase
		endfunction

		function void note_item(in_t it);
			out_t        e;
			int unsigned n;
			if (it.opcode == OP_PUSH) begin
				if (!rx_on)
					return;
				ring[wr_ptr] = it.rx_byte;
				wr_ptr = step_ptr(wr_ptr);
				fill = fill + 7'd1;
				e = '0;
				if (fill >= span()) begin
					// overflow: ring emptied, stored bytes kept
					wr_ptr = '0;
					rd_ptr = '0;
					fill   = '0;
					e.event_code = EV_OVERFLOW;
				end else if (fill >= thr_reg) begin
					e.event_code = EV_THRESHOLD;
				end
				if (!ev_on)
					e.event_code = EV_NONE;
				e.fill_level = fill;
				expected_q.push_back(e);
			end else begin
				n = 32'((it.read_count > RESULT_LIMIT) ? RESULT_LIMIT : it.read_count);
				for (int k = 0; k < n; k++) begin
					e = '0;
					// over-read still returns the byte under the pointer
					e.underflow = (fill == '0);
					e.data_byte = ring[rd_ptr];
					rd_ptr = step_ptr(rd_ptr);
					if (!e.underflow)
						fill = fill - 7'd1;
					e.last_of_read = (k == n - 1);
					e.fill_level = fill;
					expected_q.push_back(e);
				end
			end
		endfunction

		function void check_result(out_t got);
			out_t want;
			if (expected_q.size() == 0) begin
				faults++;
				if (faults <= REPORT_LIMIT)
					$display("%0t: unexpected result ev=%0d byte=%02h last=%0b uf=%0b fill=%0d",
						$realtime, got.event_code, got.data_byte, got.last_of_read,
						got.underflow, got.fill_level);
				return;
			end
			want = expected_q.pop_front();
			if (got !== want) begin
				faults++;
				if (faults <= REPORT_LIMIT)
					$display({"%0t: result mismatch exp ev=%0d byte=%02h last=%0b uf=%0b fill=%0d",
						" / got ev=%0d byte=%02h last=%0b uf=%0b fill=%0d"}, $realtime,
						want.event_code, want.data_byte, want.last_of_read, want.underflow,
						want.fill_level, got.event_code, got.data_byte, got.last_of_read,
						got.underflow, got.fill_level);
			end
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// Clock, reset and block under test
	// ------------------------------------------------------------------------
	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	in_t                  in_data   = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	out_t                 out_data;
	logic                 cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [LEN_W-1:0]     cfg_data  = '0;

	ring_scoreboard sb = new();

	int unsigned hold_requests = 0;  // bumped by the stimulus, seen by the receiver
	int unsigned burst_left    = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	rx_ring_buffer_with_threshold_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// every delivered result item goes straight to the scoreboard
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(out_data);
	end

	// Receiver: ready-high runs broken by short stalls, now and then a quiet
	// stretch with no stalls, and a long hold-off whenever one is requested.
	initial begin : receiver
		int unsigned high_left;
		int unsigned low_left;
		int unsigned hold_left;
		int unsigned holds_seen;
		high_left  = 0;
		low_left   = 0;
		hold_left  = 0;
		holds_seen = 0;
		forever begin
			@(negedge clk);
			if (hold_requests != holds_seen) begin
				holds_seen = hold_requests;
				hold_left  = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (high_left > 0) begin
				high_left--;
				out_ready <= 1'b1;
			end else if (low_left > 0) begin
				low_left--;
				out_ready <= 1'b0;
			end else begin
				if ($urandom_range(0, 7) == 0) begin
					high_left = $urandom_range(30, 80);
					low_left  = 0;
				end else begin
					high_left = $urandom_range(0, 11);
					low_left  = $urandom_range(1, 4);
				end
				out_ready <= 1'b1;
			end
		end
	end

	// guard against a hung handshake
	initial begin
		#5_000_000;
		$display("** rx_ring_buffer_with_threshold_unit: FAILED **");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Drivers: inputs change on the falling edge, handshakes seen on the rising
	// ------------------------------------------------------------------------
	task automatic send_item(in_t it);
		@(negedge clk);
		in_valid <= 1'b1;
		in_data  <= it;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_item(it);
	endtask

	task automatic idle(int unsigned n);
		@(negedge clk);
		in_valid <= 1'b0;
		repeat (n - 1)
			@(negedge clk);
	endtask

	// bursts of back-to-back items with random gaps between them
	task automatic pace();
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			idle($urandom_range(1, 6));
			burst_left = $urandom_range(0, 10);
		end
	endtask

	// stop offering items until every outstanding result has come back
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES)
			@(negedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [LEN_W-1:0] val);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		sb.write_reg(idx, val);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic set_config(logic [LEN_W-1:0] len, logic [LEN_W-1:0] thr, bit rx, bit ev);
		drain();
		write_reg(CFG_LENGTH, len);
		write_reg(CFG_THRESHOLD, thr);
		write_reg(CFG_RX_EN, {6'd0, rx});
		write_reg(CFG_EV_EN, {6'd0, ev});
	endtask

	function automatic in_t make_item(opcode_t op, logic [BYTE_W-1:0] b, logic [LEN_W-1:0] c);
		in_t it;
		it.opcode     = op;
		it.rx_byte    = b;
		it.read_count = c;
		return it;
	endfunction

	// mostly short reads; the odd long one, counts above 64 included
	function automatic in_t rand_item(int unsigned push_pct);
		opcode_t op;
		op = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_READ;
		return make_item(op, BYTE_W'($urandom_range(0, 255)),
			LEN_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
				: $urandom_range(0, 6)));
	endfunction

	// One random phase: new settings, a run of pushes to climb the ring, then
	// a push/read mix. Optionally the receiver holds off at the start so the
	// block backs up while items keep coming.
	task automatic run_phase(logic [LEN_W-1:0] len, logic [LEN_W-1:0] thr, bit rx, bit ev,
			int unsigned items, int unsigned lead_pushes, int unsigned push_pct, bit hold);
		set_config(len, thr, rx, ev);
		if (hold) begin
			@(posedge clk);
			hold_requests++;
			burst_left = 20;
		end
		for (int unsigned i = 0; i < items; i++) begin
			send_item((i < lead_pushes) ? rand_item(100) : rand_item(push_pct));
			pace();
		end
	endtask

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	initial begin : stimulus
		logic [LEN_W-1:0] len;
		repeat (6)
			@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: reception off, so the push is dropped; zero-count read
		// gives nothing; a single read over the cleared store underflows
		send_item(make_item(OP_PUSH, 8'hFF, 7'h7F));
		send_item(make_item(OP_READ, 8'h00, 7'd0));
		send_item(make_item(OP_READ, 8'hFF, 7'd1));

		// short ring: threshold events, overflow on the fourth push, then an
		// over-long read clipped to 64 items that runs well past empty
		set_config(7'd4, 7'd2, 1'b1, 1'b1);
		send_item(make_item(OP_PUSH, 8'h00, 7'd0));
		send_item(make_item(OP_PUSH, 8'hFF, 7'd0));
		send_item(make_item(OP_PUSH, 8'hA5, 7'd0));
		send_item(make_item(OP_PUSH, 8'h5A, 7'd0));
		send_item(make_item(OP_PUSH, 8'h3C, 7'd0));
		send_item(make_item(OP_PUSH, 8'hC3, 7'd0));
		send_item(make_item(OP_READ, 8'h00, 7'd127));
		send_item(make_item(OP_READ, 8'hFF, 7'd0));

		// length below the minimum clamps to two; events off hides the overflow
		set_config(7'd1, 7'd0, 1'b1, 1'b0);
		send_item(make_item(OP_PUSH, 8'h81, 7'd0));
		send_item(make_item(OP_PUSH, 8'h7E, 7'd0));
		send_item(make_item(OP_READ, 8'h00, 7'd3));

		// same ring with events on: zero threshold fires on the first byte
		set_config(7'd1, 7'd0, 1'b1, 1'b1);
		send_item(make_item(OP_PUSH, 8'h11, 7'd0));
		send_item(make_item(OP_PUSH, 8'h22, 7'd0));

		// length zero, threshold at its top value: never reached
		set_config(7'd0, 7'd127, 1'b1, 1'b1);
		send_item(make_item(OP_PUSH, 8'h33, 7'd64));
		send_item(make_item(OP_READ, 8'h00, 7'd2));

		// reception off again: push dropped, read still served
		set_config(7'd0, 7'd127, 1'b0, 1'b1);
		send_item(make_item(OP_PUSH, 8'h44, 7'd0));
		send_item(make_item(OP_READ, 8'h00, 7'd1));

		// random phases
		run_phase(7'd8, 7'd5, 1'b1, 1'b1, 14, 6, 70, 1'b0);
		// full-size ring (length written above the maximum), 64 straight pushes
		// to reach threshold and overflow, with the receiver held off meanwhile
		run_phase(7'd127, 7'd63, 1'b1, 1'b1, 74, 64, 70, 1'b1);
		run_phase(7'd64, 7'd64, 1'b1, 1'b1, 12, 4, 60, 1'b0);
		repeat (2) begin
			len = LEN_W'($urandom_range(2, 12));
			run_phase(len, LEN_W'($urandom_range(0, len + 1)), $urandom_range(0, 4) != 0,
				$urandom_range(0, 1) != 0, 12, $urandom_range(0, len), 65, 1'b0);
		end
		drain();

		if (sb.expected_q.size() != 0) begin
			$display("%0d result items never arrived", sb.expected_q.size());
			sb.faults++;
		end
		if (sb.faults == 0)
			$display("** rx_ring_buffer_with_threshold_unit: PASSED **");
		else
			$display("** rx_ring_buffer_with_threshold_unit: FAILED **");
		$finish;
	end

endmodule

// ===== files.f =====
design/rxrb_pkg.sv
design/rxrb_ctrl.sv
design/rxrb_dpath.sv
design/rx_ring_buffer_with_threshold_unit.sv
verif/rx_ring_buffer_with_threshold_unit_test.sv
